>>> hdl/replay_action_stream_decoder_macros.svh
// assertion macros for the replay action stream decoder
`ifndef REPLAY_ACTION_STREAM_DECODER_MACROS_SVH
`define REPLAY_ACTION_STREAM_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define RASD_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define RASD_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define RASD_ASSERT_IMP(label, clk, rstn, a, c)
`define RASD_ASSERT_NXT(label, clk, rstn, a, c)
`endif
`endif

>>> hdl/rasd_pkg.sv
// shared types and constants of the replay action stream decoder
`timescale 1ns / 1ps
package rasd_pkg;
    localparam logic [1:0] KIND_ACTION = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_SIGNATURE = 4'd1;
    localparam logic [3:0] ERR_VERSION   = 4'd2;
    localparam logic [3:0] ERR_TRUNCATED = 4'd3;
    localparam logic [3:0] ERR_VARINT    = 4'd4;
    localparam logic [3:0] ERR_FRAME     = 4'd6;
    localparam logic [3:0] ERR_V1_KIND   = 4'd7;
    localparam logic [3:0] ERR_DELTA_OVF = 4'd8;
    localparam logic [3:0] ERR_FRAME_OVF = 4'd9;

    localparam logic [30:0] FRAME_MAX = 31'h7fffffff;

    // one queued command between front and back: up to two results
    typedef struct packed {
        logic [1:0]  count;     // 1 or 2 results
        logic        fin2;      // second result of a pair is the finish
        logic [1:0]  kind;
        logic [30:0] frame;
        logic        player2;
        logic [3:0]  err;
    } rasd_cmd_t;

    function automatic logic [7:0] sig_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0: b = 8'h9f;   4'd1: b = 8'h88;   4'd2: b = 8'h89;   4'd3: b = 8'h84;
            4'd4: b = 8'h9f;   4'd5: b = 8'h3b;   4'd6: b = 8'h1d;   4'd7: b = 8'hd8;
            4'd8: b = 8'hcc;   4'd9: b = 8'ha1;   4'd10: b = 8'h86;  4'd11: b = 8'h8a;
            4'd12: b = 8'h88;  4'd13: b = 8'h99;  4'd14: b = 8'h84;  default: b = 8'h00;
        endcase
        return b;
    endfunction
endpackage

>>> hdl/rasd_front.sv
// front end: parses bytes and turns them into result commands
`timescale 1ns / 1ps
module rasd_front import rasd_pkg::*; #(
    parameter int META_BYTES = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_eof,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output rasd_cmd_t  cmd
);
    localparam logic [3:0] PH_HEADER = 4'd0, PH_META = 4'd1, PH_V1_COUNT = 4'd2,
        PH_V1_FRAME = 4'd3, PH_V1_FLAGS = 4'd4, PH_V2_START = 4'd5, PH_V2_FLAGS = 4'd6,
        PH_V2_SKIP = 4'd7, PH_V2_DELTA = 4'd8, PH_DONE = 4'd9, PH_FAILED = 4'd10;

    logic [3:0]  phase_reg, phase_next;
    logic [6:0]  pos_reg, pos_next;
    logic [1:0]  ver_reg, ver_next;
    logic [31:0] vacc_reg, vacc_next;
    logic [2:0]  vidx_reg, vidx_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] rframe_reg, rframe_next;
    logic [63:0] cur_reg, cur_next;
    logic [63:0] prev_reg, prev_next;
    logic [63:0] dacc_reg, dacc_next;
    logic [7:0]  flags_reg, flags_next;
    logic [3:0]  skip_reg, skip_next;

    logic        emit;
    rasd_cmd_t   c;
    logic        accept;

    assign in_ready  = cmd_ready;
    assign accept    = in_valid && in_ready;
    assign cmd_valid = accept && emit;
    assign cmd       = c;

    // delta length from a flag byte
    function automatic logic [2:0] dlen(input logic [7:0] f);
        return (f[7:6] == 2'd3) ? 3'd4 : {1'b0, f[7:6]};
    endfunction

    always_comb begin
        logic        vdone, verr;
        logic [31:0] vval, vor;
        logic [4:0]  sh;
        logic [63:0] base, d, dsum;
        logic        dovf, fovf, do_after, fin;
        logic [7:0]  hf;
        logic [3:0]  sk;
        logic [2:0]  kd;
        phase_next = phase_reg; pos_next = pos_reg; ver_next = ver_reg;
        vacc_next = vacc_reg; vidx_next = vidx_reg; rem_next = rem_reg;
        rframe_next = rframe_reg; cur_next = cur_reg; prev_next = prev_reg;
        dacc_next = dacc_reg; flags_next = flags_reg; skip_next = skip_reg;
        emit = 1'b0;
        c = '{count: 2'd1, fin2: 1'b0, kind: KIND_ACTION, frame: '0, player2: 1'b0,
              err: ERR_NONE};
        vdone = 1'b0; verr = 1'b0; vval = '0; vor = '0; sh = '0;
        base = '0; d = '0; dsum = '0; dovf = 1'b0; fovf = 1'b0;
        do_after = 1'b0; fin = 1'b0; hf = flags_reg; sk = '0; kd = in_byte[2:0];

        // varint digit, shared by all varint phases
        sh  = 5'(7 * int'(vidx_reg[1:0])) + ((vidx_reg[2]) ? 5'd28 : 5'd0);
        vor = vacc_reg | (32'(in_byte[6:0]) << sh);
        if (vidx_reg >= 3'd4 && in_byte[7:4] != 4'd0) verr = 1'b1;
        else if (!in_byte[7]) vdone = 1'b1;

        if (phase_reg == PH_DONE || phase_reg == PH_FAILED) begin
            // idle until reset
        end else if (in_eof) begin
            emit = 1'b1;
            if (phase_reg == PH_V2_FLAGS) begin
                c.kind = KIND_FINISH; phase_next = PH_DONE;
            end else begin
                c.kind = KIND_ERROR; c.err = ERR_TRUNCATED; phase_next = PH_FAILED;
            end
        end else begin
            case (phase_reg)
                PH_HEADER: begin
                    if (in_byte != sig_byte(pos_reg[3:0])) begin
                        emit = 1'b1; c.kind = KIND_ERROR; c.err = ERR_SIGNATURE;
                        phase_next = PH_FAILED;
                    end else if (pos_reg == 7'd15) begin
                        pos_next = '0; phase_next = PH_META;
                    end else pos_next = pos_reg + 7'd1;
                end
                PH_META: begin
                    if (pos_reg == 7'd0)
                        ver_next = (in_byte == 8'd1) ? 2'd1 : (in_byte == 8'd2) ? 2'd2 : 2'd0;
                    if (pos_reg == 7'(META_BYTES - 1)) begin
                        pos_next = '0; vacc_next = '0; vidx_next = '0;
                        if (ver_next == 2'd1) phase_next = PH_V1_COUNT;
                        else if (ver_next == 2'd2) phase_next = PH_V2_START;
                        else begin
                            emit = 1'b1; c.kind = KIND_ERROR; c.err = ERR_VERSION;
                            phase_next = PH_FAILED;
                        end
                    end else pos_next = pos_reg + 7'd1;
                end
                PH_V1_COUNT, PH_V1_FRAME, PH_V2_START: begin
                    if (verr) begin
                        emit = 1'b1; c.kind = KIND_ERROR; c.err = ERR_VARINT;
                        phase_next = PH_FAILED;
                    end else if (vdone) begin
                        vval = vor; vacc_next = '0; vidx_next = '0;
                        if (phase_reg == PH_V1_COUNT) begin
                            rem_next = vval;
                            if (vval == 32'd0) begin
                                emit = 1'b1; c.kind = KIND_FINISH; phase_next = PH_DONE;
                            end else phase_next = PH_V1_FRAME;
                        end else if (phase_reg == PH_V1_FRAME) begin
                            rframe_next = vval; phase_next = PH_V1_FLAGS;
                        end else begin
                            cur_next = 64'(vval); phase_next = PH_V2_FLAGS;
                        end
                    end else begin
                        vacc_next = vor; vidx_next = vidx_reg + 3'd1;
                    end
                end
                PH_V1_FLAGS: begin
                    if (kd < 3'd3 && rframe_reg[31]) begin
                        emit = 1'b1; c.kind = KIND_ERROR; c.err = ERR_FRAME;
                        phase_next = PH_FAILED;
                    end else if (kd > 3'd5) begin
                        emit = 1'b1; c.kind = KIND_ERROR; c.err = ERR_V1_KIND;
                        phase_next = PH_FAILED;
                    end else begin
                        rem_next = rem_reg - 32'd1;
                        if (kd < 3'd3) begin
                            emit = 1'b1; c.frame = rframe_reg[30:0]; c.player2 = in_byte[6];
                        end
                        if (rem_next == 32'd0) begin
                            fin = 1'b1; phase_next = PH_DONE;
                        end else phase_next = PH_V1_FRAME;
                        if (fin) begin
                            if (emit) begin
                                c.count = 2'd2; c.fin2 = 1'b1;
                            end else begin
                                emit = 1'b1; c.kind = KIND_FINISH;
                            end
                        end
                    end
                end
                PH_V2_FLAGS: begin
                    flags_next = in_byte; hf = in_byte;
                    if (in_byte[1:0] != 2'd0) begin
                        if (cur_reg[63:31] != '0) begin
                            emit = 1'b1; c.kind = KIND_ERROR; c.err = ERR_FRAME;
                            phase_next = PH_FAILED;
                        end else begin
                            emit = 1'b1; c.frame = cur_reg[30:0]; c.player2 = in_byte[3];
                            c.count = in_byte[4] ? 2'd2 : 2'd1;
                        end
                    end else if (in_byte[3:2] == 2'd3) begin
                        sk = in_byte[4] ? 4'd0 : 4'd4;
                    end else begin
                        sk = in_byte[4] ? 4'd8 : 4'd0; cur_next = '0;
                    end
                    if (phase_next != PH_FAILED) begin
                        if (sk != 4'd0) begin
                            skip_next = sk; phase_next = PH_V2_SKIP;
                        end else do_after = 1'b1;
                    end
                end
                PH_V2_SKIP: begin
                    skip_next = (skip_reg != 4'd0) ? skip_reg - 4'd1 : 4'd0;
                    if (skip_next == 4'd0) do_after = 1'b1;
                end
                PH_V2_DELTA: begin
                    dacc_next = dacc_reg | (64'(in_byte) << {pos_reg[1:0], 3'b000});
                    pos_next = pos_reg + 7'd1;
                    if (pos_next[2:0] >= dlen(flags_reg)) begin
                        pos_next = '0; fin = 1'b1;
                    end
                end
                default: phase_next = PH_FAILED;
            endcase

            if (do_after) begin
                dacc_next = '0; pos_next = '0;
                if (dlen(hf) != 3'd0) phase_next = PH_V2_DELTA;
                else fin = 1'b1;
            end
            if (fin && (phase_reg == PH_V2_FLAGS || phase_reg == PH_V2_SKIP
                        || phase_reg == PH_V2_DELTA)) begin
                phase_next = PH_V2_FLAGS;
                base = hf[5] ? prev_reg : 64'd0;
                {dovf, dsum} = {1'b0, dacc_next} + {1'b0, base};
                if (dovf) begin
                    emit = 1'b1; c = '{count: 2'd1, fin2: 1'b0, kind: KIND_ERROR, frame: '0,
                                       player2: 1'b0, err: ERR_DELTA_OVF};
                    phase_next = PH_FAILED;
                end else begin
                    d = dsum; dacc_next = '0;
                    if (dlen(hf) != 3'd0 && d != 64'd0) prev_next = d;
                    {fovf, cur_next} = {1'b0, cur_next} + {1'b0, d};
                    if (fovf) begin
                        cur_next = cur_reg;
                        emit = 1'b1; c = '{count: 2'd1, fin2: 1'b0, kind: KIND_ERROR,
                                           frame: '0, player2: 1'b0, err: ERR_FRAME_OVF};
                        phase_next = PH_FAILED;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER; pos_reg <= '0; ver_reg <= '0; vacc_reg <= '0;
            vidx_reg <= '0; rem_reg <= '0; rframe_reg <= '0; cur_reg <= '0;
            prev_reg <= '0; dacc_reg <= '0; flags_reg <= '0; skip_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next; pos_reg <= pos_next; ver_reg <= ver_next;
            vacc_reg <= vacc_next; vidx_reg <= vidx_next; rem_reg <= rem_next;
            rframe_reg <= rframe_next; cur_reg <= cur_next; prev_reg <= prev_next;
            dacc_reg <= dacc_next; flags_reg <= flags_next; skip_reg <= skip_next;
        end
    end
endmodule

>>> hdl/rasd_queue.sv
// short command queue between the parser and the result sequencer
`timescale 1ns / 1ps
`include "replay_action_stream_decoder_macros.svh"
module rasd_queue import rasd_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  rasd_cmd_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output rasd_cmd_t rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    rasd_cmd_t      mem_reg [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;
    logic           wr, rd;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    `RASD_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= (AW+1)'(DEPTH))
    `RASD_ASSERT_NXT(a_fill, aclk, aresetn, wr && !rd, cnt_reg == $past(cnt_reg) + 1'b1)
    `RASD_ASSERT_NXT(a_drain, aclk, aresetn, rd && !wr, cnt_reg == $past(cnt_reg) - 1'b1)
endmodule

>>> hdl/rasd_back.sv
// back end: plays each queued command out as one or two result beats
`timescale 1ns / 1ps
`include "replay_action_stream_decoder_macros.svh"
module rasd_back import rasd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  rasd_cmd_t   cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [30:0] m_action_frame,
    output logic        m_second_player,
    output logic [3:0]  m_error_code,
    output logic        m_last_of_run
);
    logic second_reg; // first of a pair already sent
    logic beat;
    logic fin_beat;

    assign m_valid = cmd_valid;
    assign beat = m_valid && m_ready;
    assign m_last_of_run = (cmd.count == 2'd1) || second_reg;
    assign cmd_ready = beat && m_last_of_run;
    // in an action+finish pair the second beat is the finish
    assign fin_beat        = second_reg && cmd.fin2;
    assign m_result_kind   = fin_beat ? KIND_FINISH : cmd.kind;
    assign m_action_frame  = fin_beat ? '0 : cmd.frame;
    assign m_second_player = fin_beat ? 1'b0 : cmd.player2;
    assign m_error_code    = cmd.err;

    always_ff @(posedge aclk) begin
        if (!aresetn) second_reg <= 1'b0;
        else if (beat) second_reg <= !m_last_of_run;
    end

    `RASD_ASSERT_IMP(a_pair_only, aclk, aresetn, second_reg, cmd_valid && cmd.count == 2'd2)
    `RASD_ASSERT_NXT(a_pair_end, aclk, aresetn, beat && second_reg, !second_reg)
    `RASD_ASSERT_NXT(a_valid_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
endmodule

>>> hdl/replay_action_stream_decoder.sv
// top level of the replay action stream decoder
`timescale 1ns / 1ps
// replay action stream decoder
// input channel s_*: one file byte per beat (s_data_byte), or an end marker
// (s_end_of_file high, byte ignored). every beat is parsed in the cycle it is
// accepted; one byte is taken each cycle while the command queue has room.
// result channel m_*: action events, one completion or one numbered error;
// m_last_of_run flags the last result caused by an input beat. a flag byte
// with the swift bit gives two beats for one input.
// a result is registered in the command queue when its input beat is accepted.
// throughput: one input beat per cycle while the command queue has room; a
// two-result input holds the result channel for both of its result beats.
// structure: parser front end -> two-entry command queue -> sequencer that
// plays each command out; a stalled receiver fills the queue and then
// lowers s_ready, nothing is lost.
// reset (aresetn low, synchronous) returns the parser to the signature
// check and empties the queue. after a finish or error all input is
// consumed and ignored until the next reset.
module replay_action_stream_decoder import rasd_pkg::*; #(
    parameter int META_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [30:0] m_action_frame,
    output logic        m_second_player,
    output logic [3:0]  m_error_code,
    output logic        m_last_of_run
);
    logic      f_valid, f_ready, q_valid, q_ready;
    rasd_cmd_t f_cmd, q_cmd;

    // parser front end
    rasd_front #(.META_BYTES(META_BYTES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_byte(s_data_byte), .in_eof(s_end_of_file),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    // decoupling queue
    rasd_queue #(.DEPTH(2)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    // result sequencer
    rasd_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_kind(m_result_kind), .m_action_frame(m_action_frame),
        .m_second_player(m_second_player), .m_error_code(m_error_code),
        .m_last_of_run(m_last_of_run)
    );
endmodule

>>> tb/sv/tb_replay_action_stream_decoder.sv
// testbench for the replay action stream decoder: one long version-2 file, predicted and scoreboarded
`timescale 1ns / 1ps

// one expected or observed result beat
typedef struct {
    logic [1:0]  kind;
    logic [30:0] frame;
    logic        p2;
    logic [3:0]  err;
    logic        last;
} replay_result_t;

// parser state of the predictor
typedef enum int {
    ST_HEADER, ST_META, ST_V1_COUNT, ST_V1_FRAME, ST_V1_FLAGS,
    ST_V2_START, ST_V2_FLAGS, ST_V2_SKIP, ST_V2_DELTA, ST_DONE, ST_FAILED
} parse_state_t;

class replay_scoreboard;
    int                  meta_bytes;
    int                  errors;
    replay_result_t      expected_results[$];
    replay_result_t      step_results[$];
    logic [7:0]          sig_table[16];
    parse_state_t        st;
    int                  pos;
    int                  version;
    logic [31:0]         vacc;
    int                  vdig;
    logic [31:0]         records_left;
    logic [31:0]         rec_frame;
    logic [63:0]         frame_now;
    logic [63:0]         prev_delta;
    logic [63:0]         delta_acc;
    logic [7:0]          flags;
    int                  skip_left;

    function new(int meta);
        meta_bytes = meta;
        errors = 0;
        sig_table = '{8'h9f, 8'h88, 8'h89, 8'h84, 8'h9f, 8'h3b, 8'h1d, 8'hd8,
                      8'hcc, 8'ha1, 8'h86, 8'h8a, 8'h88, 8'h99, 8'h84, 8'h00};
        st = ST_HEADER;
        pos = 0;
        version = 0;
        vacc = 0;
        vdig = 0;
        records_left = 0;
        rec_frame = 0;
        frame_now = 0;
        prev_delta = 0;
        delta_acc = 0;
        flags = 0;
        skip_left = 0;
    endfunction

    function void emit(logic [1:0] kind, logic [63:0] frame, logic p2, logic [3:0] err);
        replay_result_t r;
        r.kind = kind;
        r.frame = frame[30:0];
        r.p2 = p2;
        r.err = err;
        r.last = 1'b0;
        step_results = {step_results, r};
    endfunction

    function void abort(logic [3:0] err);
        emit(rasd_pkg::KIND_ERROR, 64'd0, 1'b0, err);
        st = ST_FAILED;
    endfunction

    // -1 more digits, 0 complete, else error code
    function int feed_varint(logic [7:0] b, output logic [31:0] val);
        int i;
        i = vdig;
        val = 0;
        if (i >= 4 && b[7:4] != 4'd0) return 4;
        vacc = vacc | (32'(b[6:0]) << ((7 * i) % 32));
        if (!b[7]) begin
            val = vacc;
            vacc = 0;
            vdig = 0;
            return 0;
        end
        vdig = (i + 1) & 7;
        if (vdig >= 5) return 5;
        return -1;
    endfunction

    function int delta_bytes(logic [7:0] f);
        return (f[7:6] == 2'd3) ? 4 : int'(f[7:6]);
    endfunction

    function logic [3:0] close_delta();
        logic [63:0] base;
        logic [63:0] d;
        base = flags[5] ? prev_delta : 64'd0;
        st = ST_V2_FLAGS;
        if (delta_acc > ~64'd0 - base) return rasd_pkg::ERR_DELTA_OVF;
        d = base + delta_acc;
        delta_acc = 0;
        if (delta_bytes(flags) != 0 && d != 0) prev_delta = d;
        if (frame_now > ~64'd0 - d) return rasd_pkg::ERR_FRAME_OVF;
        frame_now = frame_now + d;
        return rasd_pkg::ERR_NONE;
    endfunction

    function logic [3:0] payload_done();
        delta_acc = 0;
        pos = 0;
        if (delta_bytes(flags) != 0) begin
            st = ST_V2_DELTA;
            return rasd_pkg::ERR_NONE;
        end
        return close_delta();
    endfunction

    // works out the results of one accepted input beat
    function void note_beat(logic [7:0] b, logic eof);
        logic [31:0] val;
        int          vr;
        logic [3:0]  e;
        int          skip;
        logic        p2;
        step_results.delete();
        if (st == ST_DONE || st == ST_FAILED) return;
        if (eof) begin
            if (st == ST_V2_FLAGS) begin
                emit(rasd_pkg::KIND_FINISH, 64'd0, 1'b0, rasd_pkg::ERR_NONE);
                st = ST_DONE;
            end else begin
                abort(rasd_pkg::ERR_TRUNCATED);
            end
        end else begin
            case (st)
                ST_HEADER: begin
                    if (b != sig_table[pos & 15]) begin
                        abort(rasd_pkg::ERR_SIGNATURE);
                    end else begin
                        pos++;
                        if (pos >= 16) begin
                            pos = 0;
                            st = ST_META;
                        end
                    end
                end
                ST_META: begin
                    if (pos == 0) version = (b == 8'd1) ? 1 : (b == 8'd2) ? 2 : 0;
                    pos++;
                    if (pos >= meta_bytes) begin
                        pos = 0;
                        vacc = 0;
                        vdig = 0;
                        if (version == 1) st = ST_V1_COUNT;
                        else if (version == 2) st = ST_V2_START;
                        else abort(rasd_pkg::ERR_VERSION);
                    end
                end
                ST_V1_COUNT, ST_V1_FRAME, ST_V2_START: begin
                    vr = feed_varint(b, val);
                    if (vr > 0) begin
                        abort(4'(vr));
                    end else if (vr == 0) begin
                        if (st == ST_V1_COUNT) begin
                            records_left = val;
                            if (val == 0) begin
                                emit(rasd_pkg::KIND_FINISH, 64'd0, 1'b0, rasd_pkg::ERR_NONE);
                                st = ST_DONE;
                            end else begin
                                st = ST_V1_FRAME;
                            end
                        end else if (st == ST_V1_FRAME) begin
                            rec_frame = val;
                            st = ST_V1_FLAGS;
                        end else begin
                            frame_now = 64'(val);
                            st = ST_V2_FLAGS;
                        end
                    end
                end
                ST_V1_FLAGS: begin
                    if (b[2:0] < 3'd3 && rec_frame > 32'h7fffffff) begin
                        abort(rasd_pkg::ERR_FRAME);
                    end else if (b[2:0] > 3'd5) begin
                        abort(rasd_pkg::ERR_V1_KIND);
                    end else begin
                        if (b[2:0] < 3'd3)
                            emit(rasd_pkg::KIND_ACTION, 64'(rec_frame), b[6], rasd_pkg::ERR_NONE);
                        records_left = records_left - 1;
                        if (records_left == 0) begin
                            emit(rasd_pkg::KIND_FINISH, 64'd0, 1'b0, rasd_pkg::ERR_NONE);
                            st = ST_DONE;
                        end else begin
                            st = ST_V1_FRAME;
                        end
                    end
                end
                ST_V2_FLAGS: begin
                    skip = 0;
                    flags = b;
                    if (b[1:0] != 2'd0) begin
                        p2 = b[3];
                        if (frame_now > 64'h7fffffff) begin
                            abort(rasd_pkg::ERR_FRAME);
                            skip = -1;
                        end else begin
                            emit(rasd_pkg::KIND_ACTION, frame_now, p2, rasd_pkg::ERR_NONE);
                            if (b[4]) emit(rasd_pkg::KIND_ACTION, frame_now, p2, rasd_pkg::ERR_NONE);
                        end
                    end else if (b[3:2] == 2'd3) begin
                        skip = b[4] ? 0 : 4;
                    end else begin
                        skip = b[4] ? 8 : 0;
                        frame_now = 0;
                    end
                    if (skip > 0) begin
                        skip_left = skip;
                        st = ST_V2_SKIP;
                    end else if (skip == 0) begin
                        e = payload_done();
                        // an overflowing delta replaces the actions of the same byte
                        if (e != rasd_pkg::ERR_NONE) begin
                            step_results.delete();
                            abort(e);
                        end
                    end
                end
                ST_V2_SKIP: begin
                    if (skip_left > 0) skip_left--;
                    if (skip_left == 0) begin
                        e = payload_done();
                        if (e != rasd_pkg::ERR_NONE) abort(e);
                    end
                end
                ST_V2_DELTA: begin
                    delta_acc = delta_acc | (64'(b) << (8 * (pos & 3)));
                    pos++;
                    if (pos >= delta_bytes(flags)) begin
                        pos = 0;
                        e = close_delta();
                        if (e != rasd_pkg::ERR_NONE) abort(e);
                    end
                end
                default: st = ST_FAILED;
            endcase
        end
        if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[k]) expected_results = {expected_results, step_results[k]};
    endfunction

    function void check_result(replay_result_t got);
        replay_result_t want;
        if (expected_results.size() == 0) begin
            $display("%0t: result beat with nothing expected (kind %0d err %0d)",
                     $time, got.kind, got.err);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got.kind !== want.kind) begin
            $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
            errors++;
        end
        if (got.frame !== want.frame) begin
            $display("%0t: frame exp %0d got %0d", $time, want.frame, got.frame);
            errors++;
        end
        if (got.p2 !== want.p2) begin
            $display("%0t: player exp %0d got %0d", $time, want.p2, got.p2);
            errors++;
        end
        if (got.err !== want.err) begin
            $display("%0t: error code exp %0d got %0d", $time, want.err, got.err);
            errors++;
        end
        if (got.last !== want.last) begin
            $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_replay_action_stream_decoder;
    import rasd_pkg::*;

    localparam int META         = 64;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TARGET_BEATS = 940;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_end_of_file;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_result_kind;
    logic [30:0] m_action_frame;
    logic        m_second_player;
    logic [3:0]  m_error_code;
    logic        m_last_of_run;

    replay_scoreboard sb;
    logic [8:0]       file_beats[$];   // {end marker, byte}
    int               idle_mode;       // 0: sender 29 receiver 82, 1: swapped, 2: none
    bit               hold_req;
    int               quiet_cycles;

    replay_action_stream_decoder #(.META_BYTES(META)) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_file   (s_end_of_file),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_action_frame  (m_action_frame),
        .m_second_player (m_second_player),
        .m_error_code    (m_error_code),
        .m_last_of_run   (m_last_of_run)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // appends one beat to the file
    function automatic void put_beat(logic [8:0] v);
        file_beats = {file_beats, v};
    endfunction

    // append a flag byte with its payload and delta bytes
    task automatic add_record(logic [7:0] f, bit rand_delta);
        int skip;
        int dlen;
        skip = 0;
        if (f[1:0] == 2'd0) begin
            if (f[3:2] == 2'd3) skip = f[4] ? 0 : 4;
            else skip = f[4] ? 8 : 0;
        end
        dlen = (f[7:6] == 2'd3) ? 4 : int'(f[7:6]);
        put_beat({1'b0, f});
        repeat (skip) put_beat({1'b0, 8'($urandom)});
        for (int k = 0; k < dlen; k++) begin
            // the top delta byte stays small so frames remain in range for long runs
            if (k == 3) put_beat({1'b0, 8'($urandom_range(0, 1))});
            else if (rand_delta) put_beat({1'b0, 8'($urandom)});
            else put_beat({1'b0, 8'(k == 0 ? 8'h05 : 8'h00)});
        end
    endtask

    // builds the whole file: signature, metadata, start frame, records, end marker
    task automatic build_file();
        logic [7:0] sig[16];
        logic [7:0] f;
        int         recs;
        sig = '{8'h9f, 8'h88, 8'h89, 8'h84, 8'h9f, 8'h3b, 8'h1d, 8'hd8,
                8'hcc, 8'ha1, 8'h86, 8'h8a, 8'h88, 8'h99, 8'h84, 8'h00};
        foreach (sig[k]) put_beat({1'b0, sig[k]});
        // version 2, then the rest of the metadata is don't-care
        put_beat({1'b0, 8'h02});
        repeat (META - 1) put_beat({1'b0, 8'($urandom)});
        // start frame as a two-digit varint
        put_beat({1'b0, 8'h85});
        put_beat({1'b0, 8'h01});
        // directed: plain, swift player two, each delta length, reuse of last delta,
        // skipped payloads, frame resets, and a zero delta that is not remembered
        add_record(8'h01, 1'b0);
        add_record(8'h1b, 1'b0);
        add_record(8'h42, 1'b0);
        add_record(8'h81, 1'b0);
        add_record(8'hc1, 1'b0);
        add_record(8'h21, 1'b0);
        add_record(8'h0c, 1'b0);
        add_record(8'h1c, 1'b0);
        add_record(8'h14, 1'b0);
        put_beat({1'b0, 8'h41});
        put_beat({1'b0, 8'h00});
        add_record(8'h3a, 1'b0);
        add_record(8'h00, 1'b0);
        // random records with periodic frame resets
        recs = 0;
        while (file_beats.size() < TARGET_BEATS) begin
            if (recs % 12 == 11) f = 8'h00;
            else f = 8'($urandom);
            add_record(f, 1'b1);
            recs++;
        end
        // end of file between actions finishes; what follows is ignored
        put_beat({1'b1, 8'($urandom)});
        put_beat({1'b0, 8'hff});
        put_beat({1'b1, 8'h00});
    endtask

    // offers every beat of the file, idling at random between beats
    task automatic send_file();
        int total;
        int pct;
        total = file_beats.size();
        for (int idx = 0; idx < total; idx++) begin
            idle_mode = (idx < total / 3) ? 0 : (idx < 2 * total / 3) ? 1 : 2;
            pct = (idle_mode == 0) ? 29 : (idle_mode == 1) ? 82 : 0;
            if (idx == (5 * total) / 6) hold_req = 1'b1;
            while ($urandom_range(0, 99) < pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid       <= 1'b1;
            s_data_byte   <= file_beats[idx][7:0];
            s_end_of_file <= file_beats[idx][8];
            do @(posedge aclk); while (!s_ready);
        end
        s_valid <= 1'b0;
    endtask

    // receiver: random stalls per idle phase, plus one long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (idle_mode == 0) m_ready <= ($urandom_range(0, 99) >= 82);
            else if (idle_mode == 1) m_ready <= ($urandom_range(0, 99) >= 29);
            else m_ready <= 1'b1;
        end
    end

    // monitor: both channels sampled at the edge, plus the stall watchdog
    always @(posedge aclk) begin
        replay_result_t got;
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_beat(s_data_byte, s_end_of_file);
            if (m_valid && m_ready) begin
                got.kind  = m_result_kind;
                got.frame = m_action_frame;
                got.p2    = m_second_player;
                got.err   = m_error_code;
                got.last  = m_last_of_run;
                sb.check_result(got);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_replay_action_stream_decoder: errors");
                $finish;
            end
        end
    end

    initial begin
        sb            = new(META);
        idle_mode     = 0;
        hold_req      = 1'b0;
        quiet_cycles  = 0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data_byte   = 8'd0;
        s_end_of_file = 1'b0;
        build_file();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_file();
        // drain, then a short settling wait
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb_replay_action_stream_decoder: clean");
        end else begin
            $display("tb_replay_action_stream_decoder: errors");
        end
        $finish;
    end
endmodule
